// ===== rtl/diff_drive_ramped_wheel_pwm_top_defines.svh =====
// assertion macros for the ramped wheel pwm block
// used by the port checker; expects clk and rst_n in scope
`ifndef DIFF_DRIVE_RAMPED_WHEEL_PWM_TOP_DEFINES_SVH
`define DIFF_DRIVE_RAMPED_WHEEL_PWM_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is applied
`define DDRWP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DDRWP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ddrwp_pkg.sv =====
// shared types and constants for the ramped wheel pwm block
// no dependencies
`timescale 1ns / 1ps

package ddrwp_pkg;

    // divider geometry
    localparam int DIVD_W = 61;
    localparam int DIVS_W = 40;
    localparam int QUOT_W = 16;

    // fixed point constants
    localparam logic [25:0] PI_Q24   = 26'd52707179;
    localparam logic [9:0]  MS_TO_US = 10'd1000;
    localparam logic [14:0] BASE_K   = 15'd20000;

    // register indexes
    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_TRACK  = 3'd1;
    localparam logic [2:0] CFG_GEAR   = 3'd2;
    localparam logic [2:0] CFG_VMAX   = 3'd3;
    localparam logic [2:0] CFG_PWM_FS = 3'd4;
    localparam logic [2:0] CFG_ACC    = 3'd5;
    localparam logic [2:0] CFG_DEC    = 3'd6;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

// ===== rtl/ddrwp_div.sv =====
// restoring divider, one quotient bit a cycle, 16-bit quotient with overflow flag
// depends on ddrwp_pkg
`timescale 1ns / 1ps

module ddrwp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ddrwp_pkg::DIVD_W-1:0]  dividend,
    input  logic [ddrwp_pkg::DIVS_W-1:0]  divisor,
    output ddrwp_pkg::div_stat_t          stat
);
    import ddrwp_pkg::*;

    localparam int REM_W = DIVS_W + QUOT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [DIVD_W-1:0] lim;

    assign lim = DIVD_W'({divisor, QUOT_W'(0)});

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            // quotient beyond 16 bits is flagged at once
            if (dividend >= lim)
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
                cnt_next  = 4'd15;
                rem_next  = dividend[REM_W-1:0];
                dsh_next  = {1'b0, divisor, (QUOT_W-1)'(0)};
                q_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath flops
    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign stat.quot = q_reg;

endmodule

// ===== rtl/diff_drive_ramped_wheel_pwm_top.sv =====
// ramped differential-drive wheel pwm, top level with sequencer and datapath
// depends on ddrwp_pkg and ddrwp_div
`timescale 1ns / 1ps

// Usage
// - input stream s_axis: one beat is a command (target speed, turn rate,
//   microsecond timestamp); output stream m_axis: one beat per command
//   (left pwm, right pwm, ramped speed)
// - cfg_wr_en/cfg_wr_index/cfg_wr_data write the seven setup registers, taken at
//   once; the user must write only while no command is in flight (not enforced)
// - a command runs from acceptance to the output register through a single
//   multiplier and a 16-step divider, which are shared; the divider runs up to
//   five times (ramp, then motor speed and pwm per wheel); a divide pass ends
//   early when its quotient overflows, and the ramp divide is skipped when the
//   speed is held or the ramp time is zero
// - s_axis_tready is high only while the sequencer is idle; one command is
//   worked at a time, so the next is taken once the last reaches the output register
// - the result sits in an output register; the next command is accepted while
//   it waits, and only the final load stalls until m_axis_tready frees it
// - reset clears the ramp state, restores register defaults and empties the
//   output register

module diff_drive_ramped_wheel_pwm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // target_speed, turn_rate, timestamp_us
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // left_pwm, right_pwm, ramped_speed
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);
    import ddrwp_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RAMP  = 5'd1;
    localparam logic [4:0] ST_RMUL  = 5'd2;
    localparam logic [4:0] ST_RDIV  = 5'd3;
    localparam logic [4:0] ST_RWAIT = 5'd4;
    localparam logic [4:0] ST_K1    = 5'd5;
    localparam logic [4:0] ST_K2    = 5'd6;
    localparam logic [4:0] ST_K3    = 5'd7;
    localparam logic [4:0] ST_K4    = 5'd8;
    localparam logic [4:0] ST_K5    = 5'd9;
    localparam logic [4:0] ST_W0    = 5'd10;
    localparam logic [4:0] ST_W1    = 5'd11;
    localparam logic [4:0] ST_W2    = 5'd12;
    localparam logic [4:0] ST_W3    = 5'd13;
    localparam logic [4:0] ST_W4    = 5'd14;
    localparam logic [4:0] ST_W5    = 5'd15;
    localparam logic [4:0] ST_W6    = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    // setup registers
    logic [13:0] radius_reg;
    logic [15:0] track_reg;
    logic [13:0] gear_reg;
    logic [15:0] vmax_reg;
    logic [9:0]  pwm_fs_reg;
    logic [15:0] acc_ms_reg;
    logic [15:0] dec_ms_reg;
    logic [25:0] t_acc_reg;
    logic [25:0] t_dec_reg;

    // ramp state
    logic signed [15:0] held_reg, held_next;
    logic [25:0]        elapsed_reg, elapsed_next;
    logic signed [15:0] aslope_reg, aslope_next;
    logic signed [15:0] dslope_reg, dslope_next;
    logic [1:0]         rise_reg, rise_next;
    logic [1:0]         fall_reg, fall_next;
    logic [31:0]        last_reg, last_next;

    // sequencer and work registers
    logic [4:0]         state_reg, state_next;
    logic signed [15:0] tgt_reg, tgt_next;
    logic signed [15:0] turn_reg, turn_next;
    logic [31:0]        now_reg, now_next;
    logic [31:0]        op_a_reg, op_a_next;
    logic [25:0]        op_b_reg, op_b_next;
    logic [57:0]        prod_reg;
    logic               neg_reg, neg_next;
    logic [25:0]        tsel_reg, tsel_next;
    logic signed [30:0] base_reg, base_next;
    logic signed [32:0] lw_reg, lw_next;
    logic [39:0]        den_reg, den_next;
    logic               side_reg, side_next;
    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    logic [47:0]        odata_reg, odata_next;

    // divider hookup
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    div_stat_t          div_stat;

    // combinational helpers
    logic               rising, falling;
    logic [1:0]         steps_n;
    logic [25:0]        e0, e1, t_cur;
    logic [31:0]        dt;
    logic [32:0]        esum;
    logic signed [15:0] slope_n;
    logic [15:0]        sat_mag;
    logic signed [33:0] n_wide;
    logic [16:0]        g6;
    logic [13:0]        radius_eff;
    logic [15:0]        vmax_eff;

    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        mag16 = x[15] ? (~x + 16'd1) : x;
    endfunction

    ddrwp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat)
    );

    assign g6         = 17'({gear_reg, 2'b00}) + 17'({gear_reg, 1'b0});
    assign radius_eff = (radius_reg == 14'd0) ? 14'd1 : radius_reg;
    assign vmax_eff   = (vmax_reg == 16'd0) ? 16'd1 : vmax_reg;

    // setup register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 14'd750;
            track_reg  <= 16'd4500;
            gear_reg   <= 14'd192;
            vmax_reg   <= 16'd14000;
            pwm_fs_reg <= 10'd255;
            acc_ms_reg <= 16'd1000;
            dec_ms_reg <= 16'd500;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                CFG_RADIUS: radius_reg <= cfg_wr_data[13:0];
                CFG_TRACK:  track_reg  <= cfg_wr_data;
                CFG_GEAR:   gear_reg   <= cfg_wr_data[13:0];
                CFG_VMAX:   vmax_reg   <= cfg_wr_data;
                CFG_PWM_FS: pwm_fs_reg <= cfg_wr_data[9:0];
                CFG_ACC:    acc_ms_reg <= cfg_wr_data;
                CFG_DEC:    dec_ms_reg <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // ramp times in microseconds
    always_ff @(posedge clk)
    begin
        t_acc_reg <= 26'(acc_ms_reg) * 26'(MS_TO_US);
        t_dec_reg <= 26'(dec_ms_reg) * 26'(MS_TO_US);
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= 58'(op_a_reg) * 58'(op_b_reg);
    end

    // ramp step decode
    always_comb
    begin
        rising  = (tgt_reg != held_reg) && (tgt_reg != 16'sd0);
        falling = (tgt_reg != held_reg) && (tgt_reg == 16'sd0);
        t_cur   = rising ? t_acc_reg : t_dec_reg;
        if (rising)
        begin
            steps_n = (rise_reg < 2'd2) ? rise_reg + 2'd1 : rise_reg;
            e0      = (rise_reg < 2'd2) ? 26'd0 : elapsed_reg;
            slope_n = (rise_reg < 2'd2) ? tgt_reg : aslope_reg;
        end
        else
        begin
            steps_n = (fall_reg < 2'd2) ? fall_reg + 2'd1 : fall_reg;
            e0      = (fall_reg < 2'd2) ? 26'd0 : elapsed_reg;
            slope_n = (fall_reg < 2'd2) ? held_reg : dslope_reg;
        end
        // time step wraps at 32 bits
        dt   = now_reg - last_reg;
        esum = 33'(e0) + 33'(dt);
        if (steps_n[1])
            e1 = (esum > 33'(t_cur)) ? t_cur : esum[25:0];
        else
            e1 = 26'd0;
    end

    // saturated magnitude of the divider result for the current sign
    always_comb
    begin
        if (neg_reg)
            sat_mag = (div_stat.ovf || div_stat.quot > 16'd32768) ? 16'd32768 : div_stat.quot;
        else
            sat_mag = (div_stat.ovf || div_stat.quot > 16'd32767) ? 16'd32767 : div_stat.quot;
    end

    // wheel numerator
    assign n_wide = side_reg ? (34'(base_reg) + 34'(lw_reg)) : (34'(base_reg) - 34'(lw_reg));

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIVD_W'(prod_reg);
        div_divisor  = DIVS_W'(tsel_reg);
        case (state_reg)
            ST_RDIV:
            begin
                div_start = 1'b1;
            end
            ST_W2:
            begin
                div_start    = 1'b1;
                div_dividend = {prod_reg[48:0], 12'd0};
                div_divisor  = den_reg;
            end
            ST_W5:
            begin
                div_start   = 1'b1;
                div_divisor = DIVS_W'(vmax_eff);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        aslope_next  = aslope_reg;
        dslope_next  = dslope_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        last_next    = last_reg;
        tgt_next     = tgt_reg;
        turn_next    = turn_reg;
        now_next     = now_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        neg_next     = neg_reg;
        tsel_next    = tsel_reg;
        base_next    = base_reg;
        lw_next      = lw_reg;
        den_next     = den_reg;
        side_next    = side_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    tgt_next   = s_axis_tdata[15:0];
                    turn_next  = s_axis_tdata[31:16];
                    now_next   = s_axis_tdata[63:32];
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP:
            begin
                tsel_next  = t_cur;
                state_next = ST_K1;
                if (rising)
                begin
                    fall_next    = 2'd0;
                    rise_next    = steps_n;
                    aslope_next  = slope_n;
                    elapsed_next = e1;
                    last_next    = now_reg;
                    neg_next     = slope_n[15];
                    op_a_next    = 32'(mag16(slope_n));
                    op_b_next    = e1;
                    if (t_cur == 26'd0)
                        held_next = slope_n;
                    else
                        state_next = ST_RMUL;
                end
                else if (falling)
                begin
                    rise_next   = 2'd0;
                    fall_next   = steps_n;
                    dslope_next = slope_n;
                    last_next   = now_reg;
                    neg_next    = slope_n[15];
                    op_a_next   = 32'(mag16(slope_n));
                    op_b_next   = t_cur - e1;
                    if (t_cur == 26'd0)
                    begin
                        held_next    = 16'sd0;
                        elapsed_next = 26'd0;
                    end
                    else
                    begin
                        elapsed_next = e1;
                        state_next   = ST_RMUL;
                    end
                end
                else
                begin
                    elapsed_next = 26'd0;
                    rise_next    = 2'd0;
                    fall_next    = 2'd0;
                end
            end
            ST_RMUL:
            begin
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (div_stat.done)
                begin
                    held_next  = neg_reg ? -div_stat.quot : div_stat.quot;
                    state_next = ST_K1;
                end
            end
            ST_K1:
            begin
                // 20000 times held speed
                op_a_next  = 32'(mag16(held_reg));
                op_b_next  = 26'(BASE_K);
                state_next = ST_K2;
            end
            ST_K2:
            begin
                // track width times turn rate
                op_a_next  = 32'(track_reg);
                op_b_next  = 26'(mag16(turn_reg));
                state_next = ST_K3;
            end
            ST_K3:
            begin
                base_next  = held_reg[15] ? -31'(prod_reg) : 31'(prod_reg);
                op_a_next  = 32'(PI_Q24);
                op_b_next  = 26'(radius_eff);
                state_next = ST_K4;
            end
            ST_K4:
            begin
                lw_next    = turn_reg[15] ? -33'(prod_reg) : 33'(prod_reg);
                state_next = ST_K5;
            end
            ST_K5:
            begin
                den_next   = prod_reg[39:0];
                side_next  = 1'b0;
                state_next = ST_W0;
            end
            ST_W0:
            begin
                neg_next   = n_wide[33];
                op_a_next  = n_wide[33] ? 32'(-n_wide) : n_wide[31:0];
                op_b_next  = 26'(g6);
                state_next = ST_W1;
            end
            ST_W1:
            begin
                state_next = ST_W2;
            end
            ST_W2:
            begin
                state_next = ST_W3;
            end
            ST_W3:
            begin
                // motor speed, then scale to pwm
                if (div_stat.done)
                begin
                    op_a_next  = 32'(sat_mag);
                    op_b_next  = 26'(pwm_fs_reg);
                    state_next = ST_W4;
                end
            end
            ST_W4:
            begin
                state_next = ST_W5;
            end
            ST_W5:
            begin
                state_next = ST_W6;
            end
            ST_W6:
            begin
                if (div_stat.done)
                begin
                    if (side_reg)
                    begin
                        right_next = neg_reg ? -sat_mag : sat_mag;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        left_next  = neg_reg ? -sat_mag : sat_mag;
                        side_next  = 1'b1;
                        state_next = ST_W0;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {held_reg, right_reg, left_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and ramp state flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            held_reg    <= '0;
            elapsed_reg <= '0;
            aslope_reg  <= '0;
            dslope_reg  <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            last_reg    <= '0;
            side_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
            aslope_reg  <= aslope_next;
            dslope_reg  <= dslope_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            last_reg    <= last_next;
            side_reg    <= side_next;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        turn_reg  <= turn_next;
        now_reg   <= now_next;
        op_a_reg  <= op_a_next;
        op_b_reg  <= op_b_next;
        neg_reg   <= neg_next;
        tsel_reg  <= tsel_next;
        base_reg  <= base_next;
        lw_reg    <= lw_next;
        den_reg   <= den_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        odata_reg <= odata_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

// ===== rtl/ddrwp_chk.sv =====
// port checker for the ramped wheel pwm block, bound to the top level
// depends on diff_drive_ramped_wheel_pwm_top_defines.svh
`timescale 1ns / 1ps
`include "diff_drive_ramped_wheel_pwm_top_defines.svh"

module ddrwp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // one command at a time: ready drops after an accepted beat
    `DDRWP_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready held after accept")

    // a stalled result beat keeps its value
    `DDRWP_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // no result in the cycle after reset is seen
    `DDRWP_ASSERT_RST(a_rst_quiet, !rst_n |=> !m_axis_tvalid, "result valid in reset")

endmodule

bind diff_drive_ramped_wheel_pwm_top ddrwp_chk u_ddrwp_chk (.*);
